FILE: rtl/core/axis_angle_rotation_matrix_defines.svh
// Assertion macros shared by the rotation matrix RTL.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH

// Check that cond holds in the same cycle as trig.
`define AARM_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("rotation matrix check failed");

// Check that cond holds in the cycle after trig.
`define AARM_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("rotation matrix check failed");

`endif

FILE: rtl/core/aarm_pkg.sv
// Types, constants and tables of the axis-angle rotation matrix block.
package aarm_pkg;

    localparam int MAX_STEPS = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] PI_Q28 = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic              zero_axis;
    } out_t;

    typedef struct packed {
        logic [31:0] sum;
        logic [34:0] rem;
        logic [31:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [31:0]       r;
        logic [2:0][31:0]  rem;
        logic [2:0][30:0]  q;
    } div_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [31:0] z;
        logic               flip;
    } cordic_t;

    typedef struct packed {
        logic [2:0][15:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } side_t;

    function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
        logic signed [31:0] v;
        begin
            case (idx)
                5'd0: v = 32'sd210828714;
                5'd1: v = 32'sd124459457;
                5'd2: v = 32'sd65760959;
                5'd3: v = 32'sd33381290;
                5'd4: v = 32'sd16755422;
                5'd5: v = 32'sd8385879;
                5'd6: v = 32'sd4193963;
                5'd7: v = 32'sd2097109;
                5'd8: v = 32'sd1048571;
                5'd9: v = 32'sd524287;
                5'd10: v = 32'sd262144;
                5'd11: v = 32'sd131072;
                5'd12: v = 32'sd65536;
                5'd13: v = 32'sd32768;
                5'd14: v = 32'sd16384;
                5'd15: v = 32'sd8192;
                5'd16: v = 32'sd4096;
                5'd17: v = 32'sd2048;
                5'd18: v = 32'sd1024;
                5'd19: v = 32'sd512;
                5'd20: v = 32'sd256;
                5'd21: v = 32'sd128;
                5'd22: v = 32'sd64;
                5'd23: v = 32'sd32;
                default: v = 32'sd0;
            endcase
            return v;
        end
    endfunction

    // Q30 product, floor toward minus infinity.
    function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] p;
        begin
            p = 68'(a) * 68'(b);
            return p[63:30];
        end
    endfunction

endpackage

FILE: rtl/core/aarm_sqrt_cell.sv
// One result bit of the square root of sum * 2^32.
module aarm_sqrt_cell #(
    parameter int BIT = 31
) (
    input  logic           clk,
    input  logic           en,
    input  aarm_pkg::sqrt_t d,
    output aarm_pkg::sqrt_t q
);
    import aarm_pkg::*;

    // low half of the radicand is all zeros, so only upper cells take sum bits
    localparam int PIDX = (BIT >= 16) ? 2 * (BIT - 16) : 0;

    sqrt_t       out_reg;
    sqrt_t       out_next;
    logic [1:0]  pair;
    logic [34:0] rem_sh;
    logic [34:0] trial;

    always_comb
    begin
        if (BIT >= 16)
        begin
            pair = d.sum[PIDX +: 2];
        end
        else
        begin
            pair = 2'b00;
        end
        rem_sh = {d.rem[32:0], pair};
        trial = {1'b0, d.root, 2'b01};
        out_next.sum = d.sum;
        if (rem_sh >= trial)
        begin
            out_next.rem = rem_sh - trial;
            out_next.root = {d.root[30:0], 1'b1};
        end
        else
        begin
            out_next.rem = rem_sh;
            out_next.root = {d.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign q = out_reg;
endmodule

FILE: rtl/core/aarm_div_cell.sv
// One quotient bit of the three axis normalizing divisions.
module aarm_div_cell (
    input  logic          clk,
    input  logic          en,
    input  aarm_pkg::div_t d,
    output aarm_pkg::div_t q
);
    import aarm_pkg::*;

    div_t        out_reg;
    div_t        out_next;
    logic [32:0] sh;

    always_comb
    begin
        out_next.r = d.r;
        for (int l = 0; l < 3; l++)
        begin
            sh = {d.rem[l], 1'b0};
            if (sh >= {1'b0, d.r})
            begin
                out_next.rem[l] = 32'(sh - {1'b0, d.r});
                out_next.q[l] = {d.q[l][29:0], 1'b1};
            end
            else
            begin
                out_next.rem[l] = sh[31:0];
                out_next.q[l] = {d.q[l][29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign q = out_reg;
endmodule

FILE: rtl/core/aarm_cordic_cell.sv
// One CORDIC rotation step.
module aarm_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             en,
    input  aarm_pkg::cordic_t d,
    output aarm_pkg::cordic_t q
);
    import aarm_pkg::*;

    cordic_t            out_reg;
    cordic_t            out_next;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [31:0] at;

    always_comb
    begin
        dx = d.y >>> STEP;
        dy = d.x >>> STEP;
        at = atan_q28(5'(STEP));
        out_next.flip = d.flip;
        if (!d.z[31])
        begin
            out_next.x = d.x - dx;
            out_next.y = d.y + dy;
            out_next.z = d.z - at;
        end
        else
        begin
            out_next.x = d.x + dx;
            out_next.y = d.y - dy;
            out_next.z = d.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign q = out_reg;
endmodule

FILE: rtl/core/axis_angle_rotation_matrix.sv
// Top level: axis-angle to 3x3 rotation matrix pipeline.
// Usage:
//   Input channel in_valid/in_ready/in_data carries the angle (Q2.13 rad)
//   and an axis of any scale. Output channel out_valid/out_ready/out_data
//   carries the nine matrix entries (row-major) and the zero_axis flag.
//   A zero axis yields the identity matrix with zero_axis set.
//   Pipeline: input stage, 32 square-root cells, 31 division cells, two
//   multiply stages, output register. The CORDIC cells run beside the
//   square-root chain. Throughput: one item per cycle unless the receiver
//   stalls; every stage is one cell of a chain. When the receiver stalls
//   with a result waiting, the whole chain holds and in_ready drops in the
//   same cycle; bubbles inside the chain are not squeezed out.
//   Reset clears all valid bits; the chain then is empty and ready.
`include "axis_angle_rotation_matrix_defines.svh"
module axis_angle_rotation_matrix #(
    parameter int CORDIC_STEPS = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  aarm_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output aarm_pkg::out_t out_data
);
    import aarm_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int SQ_CELLS = 32;
    localparam int DV_CELLS = 31;
    localparam int DIV_END = SQ_CELLS + DV_CELLS;
    localparam int DLY = DIV_END - STEPS;
    localparam int LAST = DIV_END + 3;
    localparam int SH = 30 - OUT_FRAC_BITS;
    localparam logic signed [34:0] RND = (35'sd1 <<< SH) >>> 1;
    localparam logic signed [34:0] LIM = 35'sd1 <<< OUT_FRAC_BITS;
    localparam logic [15:0] ONE16 = LIM[15:0];

    logic [LAST:0] vld_reg;
    logic [LAST:0] vld_next;
    logic          en;

    // input stage
    side_t              side_reg [0:DIV_END];
    logic signed [31:0] z0_reg;
    logic               flip0_reg;
    logic [31:0]        sum0_reg;
    side_t              side_next;
    logic signed [31:0] z0_next;
    logic               flip0_next;
    logic [31:0]        sum0_next;
    logic signed [15:0] ang_sat;
    logic signed [31:0] zs;
    logic signed [31:0] sqx;
    logic signed [31:0] sqy;
    logic signed [31:0] sqz;
    logic signed [15:0] ax [0:2];

    sqrt_t   sq [0:SQ_CELLS];
    div_t    dv [0:DV_CELLS];
    cordic_t cd [0:STEPS];
    cordic_t cd_dly [1:DLY];

    // multiply stages
    logic signed [33:0] pp_reg [0:5];
    logic signed [33:0] ns_reg [0:2];
    logic signed [33:0] c_reg;
    logic signed [33:0] t_reg;
    logic               za_reg;
    logic signed [33:0] ppt_reg [0:5];
    logic signed [33:0] ns2_reg [0:2];
    logic signed [33:0] c2_reg;
    logic               za2_reg;
    logic signed [33:0] nv [0:2];
    logic signed [33:0] cf;
    logic signed [33:0] sf;
    out_t               out_reg;
    out_t               out_next;

    function automatic logic [15:0] to_out(input logic signed [33:0] v);
        logic signed [34:0] w;
        begin
            w = (35'(v) + RND) >>> SH;
            if (w > LIM)
            begin
                w = LIM;
            end
            else if (w < -LIM)
            begin
                w = -LIM;
            end
            return w[15:0];
        end
    endfunction

    assign en = !vld_reg[LAST] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[LAST];
    assign out_data = out_reg;

    always_comb
    begin
        vld_next = {vld_reg[LAST-1:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // saturate and fold the angle, form the squared length, split signs
    always_comb
    begin
        ax[0] = in_data.axis_x;
        ax[1] = in_data.axis_y;
        ax[2] = in_data.axis_z;
        if (in_data.angle > ANGLE_LIMIT)
        begin
            ang_sat = ANGLE_LIMIT;
        end
        else if (in_data.angle < -ANGLE_LIMIT)
        begin
            ang_sat = -ANGLE_LIMIT;
        end
        else
        begin
            ang_sat = in_data.angle;
        end
        zs = 32'(ang_sat) <<< 15;
        if (zs > HALF_PI_Q28)
        begin
            z0_next = zs - PI_Q28;
            flip0_next = 1'b1;
        end
        else if (zs < -HALF_PI_Q28)
        begin
            z0_next = zs + PI_Q28;
            flip0_next = 1'b1;
        end
        else
        begin
            z0_next = zs;
            flip0_next = 1'b0;
        end
        sqx = ax[0] * ax[0];
        sqy = ax[1] * ax[1];
        sqz = ax[2] * ax[2];
        sum0_next = 32'(sqx) + 32'(sqy) + 32'(sqz);
        for (int l = 0; l < 3; l++)
        begin
            side_next.neg[l] = ax[l][15];
            side_next.mag[l] = ax[l][15] ? 16'(-ax[l]) : ax[l];
        end
        side_next.zero = (ax[0] == 16'sd0) && (ax[1] == 16'sd0) && (ax[2] == 16'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg <= z0_next;
            flip0_reg <= flip0_next;
            sum0_reg <= sum0_next;
            side_reg[0] <= side_next;
            for (int j = 1; j <= DIV_END; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // square root chain
    assign sq[0] = '{sum: sum0_reg, rem: '0, root: '0};

    for (genvar k = 0; k < SQ_CELLS; k++)
    begin : g_sqrt
        aarm_sqrt_cell #(.BIT(SQ_CELLS - 1 - k)) u_cell (
            .clk (clk),
            .en  (en),
            .d   (sq[k]),
            .q   (sq[k+1])
        );
    end

    // division chain, three lanes per cell
    always_comb
    begin
        dv[0].r = sq[SQ_CELLS].root;
        for (int l = 0; l < 3; l++)
        begin
            dv[0].rem[l] = {1'b0, side_reg[SQ_CELLS].mag[l], 15'd0};
            dv[0].q[l] = '0;
        end
    end

    for (genvar k = 0; k < DV_CELLS; k++)
    begin : g_div
        aarm_div_cell u_cell (
            .clk (clk),
            .en  (en),
            .d   (dv[k]),
            .q   (dv[k+1])
        );
    end

    // CORDIC chain and delay to line up with the division
    assign cd[0] = '{x: CORDIC_GAIN, y: '0, z: z0_reg, flip: flip0_reg};

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cordic
        aarm_cordic_cell #(.STEP(i)) u_cell (
            .clk (clk),
            .en  (en),
            .d   (cd[i]),
            .q   (cd[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_dly[1] <= cd[STEPS];
            for (int j = 2; j <= DLY; j++)
            begin
                cd_dly[j] <= cd_dly[j-1];
            end
        end
    end

    // first multiply stage: unit axis, cosine, sine
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            nv[l] = side_reg[DIV_END].neg[l] ? -34'(dv[DV_CELLS].q[l])
                                             : 34'(dv[DV_CELLS].q[l]);
        end
        cf = cd_dly[DLY].flip ? -cd_dly[DLY].x : cd_dly[DLY].x;
        sf = cd_dly[DLY].flip ? -cd_dly[DLY].y : cd_dly[DLY].y;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg[0] <= mulq(nv[0], nv[0]);
            pp_reg[1] <= mulq(nv[1], nv[1]);
            pp_reg[2] <= mulq(nv[2], nv[2]);
            pp_reg[3] <= mulq(nv[0], nv[1]);
            pp_reg[4] <= mulq(nv[0], nv[2]);
            pp_reg[5] <= mulq(nv[1], nv[2]);
            for (int l = 0; l < 3; l++)
            begin
                ns_reg[l] <= mulq(nv[l], sf);
            end
            c_reg <= cf;
            t_reg <= ONE_Q30 - cf;
            za_reg <= side_reg[DIV_END].zero;
        end
    end

    // second multiply stage: scale by one minus cosine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 6; j++)
            begin
                ppt_reg[j] <= mulq(pp_reg[j], t_reg);
            end
            ns2_reg <= ns_reg;
            c2_reg <= c_reg;
            za2_reg <= za_reg;
        end
    end

    // combine, round, saturate; identity for a zero axis
    always_comb
    begin
        if (za2_reg)
        begin
            out_next = '0;
            out_next.m00 = ONE16;
            out_next.m11 = ONE16;
            out_next.m22 = ONE16;
            out_next.zero_axis = 1'b1;
        end
        else
        begin
            out_next.m00 = to_out(ppt_reg[0] + c2_reg);
            out_next.m01 = to_out(ppt_reg[3] - ns2_reg[2]);
            out_next.m02 = to_out(ppt_reg[4] + ns2_reg[1]);
            out_next.m10 = to_out(ppt_reg[3] + ns2_reg[2]);
            out_next.m11 = to_out(ppt_reg[1] + c2_reg);
            out_next.m12 = to_out(ppt_reg[5] - ns2_reg[0]);
            out_next.m20 = to_out(ppt_reg[4] - ns2_reg[1]);
            out_next.m21 = to_out(ppt_reg[5] + ns2_reg[0]);
            out_next.m22 = to_out(ppt_reg[2] + c2_reg);
            out_next.zero_axis = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    `AARM_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_reg[0])
    `AARM_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_reg))
    `AARM_ASSERT_NOW(a_zero_identity, out_valid && out_data.zero_axis,
        out_data.m00 == ONE16 && out_data.m01 == 16'sd0 && out_data.m10 == 16'sd0)

endmodule

FILE: test/axis_angle_rotation_matrix_chk.sv
// Checker for the rotation matrix block: predicts each matrix and compares it.
`timescale 1ns / 100ps
module axis_angle_rotation_matrix_chk #(
    parameter int CORDIC_STEPS = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  aarm_pkg::in_t   in_data,
    input  logic            out_valid,
    input  logic            out_ready,
    input  aarm_pkg::out_t  out_data,
    output int              fail_count,
    output int              pending
);
    import aarm_pkg::*;

    localparam longint ONE = 64'sd1 << 30;
    localparam longint GAIN = 64'sd652032874;
    localparam longint PI = 64'sd843314857;
    localparam longint HALF_PI = 64'sd421657428;
    localparam longint LIMIT = 64'sd25736;

    out_t matrix_q[$];

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (v >= res + bit_v)
            begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end
            else
                res >>= 1;
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_part(longint a, longint unsigned r);
        longint unsigned mag;
        longint q;
        mag = (a < 0) ? -a : a;
        q = longint'((mag << 46) / r);
        return (a < 0) ? -q : q;
    endfunction

    function automatic logic [15:0] to_entry(longint v);
        int sh;
        longint lim;
        sh = 30 - OUT_FRAC_BITS;
        lim = 64'sd1 << OUT_FRAC_BITS;
        if (sh > 0)
            v = (v + (64'sd1 << (sh - 1))) >>> sh;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v[15:0];
    endfunction

    function automatic out_t rotation_of(in_t it);
        out_t m;
        longint ang, ax, ay, az, z, x, y, c, s, t, nx, ny, nz, pxy, pxz, pyz, dx, dy;
        longint unsigned sum, r;
        logic flip;
        int steps;
        ang = it.angle;
        ax = it.axis_x;
        ay = it.axis_y;
        az = it.axis_z;
        m = '0;
        if (ax == 0 && ay == 0 && az == 0)
        begin
            m.m00 = to_entry(ONE);
            m.m11 = to_entry(ONE);
            m.m22 = to_entry(ONE);
            m.zero_axis = 1'b1;
            return m;
        end
        if (ang > LIMIT)
            ang = LIMIT;
        if (ang < -LIMIT)
            ang = -LIMIT;
        z = ang * 32768;
        flip = 1'b0;
        if (z > HALF_PI)
        begin
            z -= PI;
            flip = 1'b1;
        end
        else if (z < -HALF_PI)
        begin
            z += PI;
            flip = 1'b1;
        end
        x = GAIN;
        y = 0;
        steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        for (int i = 0; i < steps; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(atan_q28(5'(i)));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(atan_q28(5'(i)));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        t = ONE - c;
        sum = ax * ax + ay * ay + az * az;
        r = int_sqrt(sum << 32);
        nx = unit_part(ax, r);
        ny = unit_part(ay, r);
        nz = unit_part(az, r);
        pxy = qmul(qmul(nx, ny), t);
        pxz = qmul(qmul(nx, nz), t);
        pyz = qmul(qmul(ny, nz), t);
        m.m00 = to_entry(qmul(qmul(nx, nx), t) + c);
        m.m01 = to_entry(pxy - qmul(nz, s));
        m.m02 = to_entry(pxz + qmul(ny, s));
        m.m10 = to_entry(pxy + qmul(nz, s));
        m.m11 = to_entry(qmul(qmul(ny, ny), t) + c);
        m.m12 = to_entry(pyz - qmul(nx, s));
        m.m20 = to_entry(pxz - qmul(ny, s));
        m.m21 = to_entry(pyz + qmul(nx, s));
        m.m22 = to_entry(qmul(qmul(nz, nz), t) + c);
        return m;
    endfunction

    assign pending = matrix_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                matrix_q.push_back(rotation_of(in_data));
            if (out_valid && out_ready)
            begin
                if (matrix_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected matrix %h", out_data);
                end
                else
                begin
                    want = matrix_q.pop_front();
                    if (want !== out_data)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: exp %h %h %h %h %h %h %h %h %h z%b",
                                want.m00, want.m01, want.m02, want.m10, want.m11,
                                want.m12, want.m20, want.m21, want.m22, want.zero_axis,
                                "\n          got %h %h %h %h %h %h %h %h %h z%b",
                                out_data.m00, out_data.m01, out_data.m02, out_data.m10,
                                out_data.m11, out_data.m12, out_data.m20, out_data.m21,
                                out_data.m22, out_data.zero_axis);
                    end
                end
            end
        end
    end
endmodule

FILE: test/axis_angle_rotation_matrix_tb.sv
// Testbench top for the rotation matrix block: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module axis_angle_rotation_matrix_tb;
    import aarm_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int LATENCY = 66;
    localparam int CYCLE_LIMIT = 200000;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    in_t   in_data;
    logic  out_valid;
    logic  out_ready;
    out_t  out_data;
    int    fail_count;
    int    pending;
    int    cycles = 0;
    logic  hold_off;

    axis_angle_rotation_matrix u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    axis_angle_rotation_matrix_chk u_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            3: return 16'(int'($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_t rand_item();
        in_t it;
        case ($urandom_range(0, 9))
            0: it.angle = 16'($urandom);
            1: it.angle = ($urandom_range(0, 1)) ? 16'sd25736 : -16'sd25736;
            default: it.angle = 16'(int'($urandom_range(0, 51472)) - 25736);
        endcase
        it.axis_x = rand_comp();
        it.axis_y = rand_comp();
        it.axis_z = rand_comp();
        if ($urandom_range(0, 30) == 0)
        begin
            it.axis_x = '0;
            it.axis_y = '0;
            it.axis_z = '0;
        end
        return it;
    endfunction

    // Offer one item, hold it until accepted.
    task automatic send(in_t it);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(posedge clk);
    endtask

    // Receiver: random stall pattern, one long hold-off while items keep coming.
    initial
    begin
        int mode;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else
            begin
                mode = (cycles / 500) % 3;
                if (mode == 0)
                    out_ready <= 1'b1;
                else if (mode == 1)
                    out_ready <= ($urandom_range(0, 3) != 0);
                else
                    out_ready <= ($urandom_range(0, 1) != 0);
            end
        end
    end

    initial
    begin
        hold_off = 1'b0;
        @(posedge rst_n);
        repeat (300)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (400)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        in_t d[$];
        in_t it;
        int burst;
        int idx;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero axis, field extremes, angle saturation and quadrant folds.
        d.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        d.push_back('{16'sd25736, 16'sd0, 16'sd0, 16'sd0});
        d.push_back('{16'sd0, 16'sd1, 16'sd0, 16'sd0});
        d.push_back('{16'sd25736, 16'sd0, 16'sd0, 16'sd1});
        d.push_back('{-16'sd25736, 16'sd0, 16'sd1, 16'sd0});
        d.push_back('{16'sh7fff, 16'sd3, 16'sd4, 16'sd5});
        d.push_back('{16'sh8000, -16'sd3, 16'sd4, -16'sd5});
        d.push_back('{16'sd12868, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        d.push_back('{-16'sd12868, 16'sh8000, 16'sh8000, 16'sh8000});
        d.push_back('{16'sd12869, 16'sh8000, 16'sh7fff, 16'sd0});
        d.push_back('{-16'sd12869, 16'sd1, -16'sd1, 16'sd1});
        d.push_back('{16'sd8580, 16'sh8000, 16'sd0, 16'sd0});
        d.push_back('{-16'sd1, 16'sd0, 16'sd0, -16'sd1});
        d.push_back('{16'sd1, 16'sh7fff, 16'sd1, 16'sh8000});
        d.push_back('{16'sd20000, -16'sd1, -16'sd1, -16'sd1});
        foreach (d[i])
            send(d[i]);

        idx = 0;
        while (idx < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && idx < RANDOM_ITEMS; b++)
            begin
                it = rand_item();
                send(it);
                idx++;
            end
            if ($urandom_range(0, 2) != 0)
                gap();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10)
            @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/aarm_pkg.sv
rtl/core/aarm_sqrt_cell.sv
rtl/core/aarm_div_cell.sv
rtl/core/aarm_cordic_cell.sv
rtl/core/axis_angle_rotation_matrix.sv
test/axis_angle_rotation_matrix_chk.sv
test/axis_angle_rotation_matrix_tb.sv
